[rtl/chg_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the Graham-scan convex hull core.
// No dependencies.
package chg_pkg;

  localparam int MAX_RESULTS = 64;  // cap on vertices emitted per set
  localparam int MIN_HULL    = 3;   // fewer points are emitted as they are
  localparam int CMP_LAT     = 2;   // pipeline stages of the turn unit

  typedef enum logic [4:0] {
    S_LOAD,
    S_PV_RD,
    S_PV_CHK,
    S_SWAP_RD,
    S_SWAP_WR,
    S_SWAP_W0,
    S_SORT_RD,
    S_SORT_KEY,
    S_INS_RD,
    S_INS_LD,
    S_INS_CMP,
    S_SC_INIT_RD,
    S_SC_INIT,
    S_SC_RD,
    S_SC_LD,
    S_SC_TEST,
    S_SC_CMP,
    S_SC_SEC,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic turn_pos;   // o->a->b turns left
    logic turn_zero;  // collinear
    logic dist_lt;    // |a-o|^2 < |b-o|^2
  } turn_res_t;

endpackage

[rtl/chg_turn.sv]
`timescale 1ns / 1ps
// Pipelined orientation and distance unit: cross product sign of o->a->b
// and squared distance compare from o. Depends on chg_pkg.
module chg_turn #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] ox,
  input  logic signed [CW-1:0] oy,
  input  logic signed [CW-1:0] ax,
  input  logic signed [CW-1:0] ay,
  input  logic signed [CW-1:0] bx,
  input  logic signed [CW-1:0] by,
  output chg_pkg::turn_res_t   res
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dax_r, day_r, dbx_r, dby_r;
  logic signed [PW-1:0] l_r, r_r, sax_r, say_r, sbx_r, sby_r;
  logic signed [PW:0]   da2, db2;

  // stage 1: differences
  always_ff @(posedge clk) begin
    dax_r <= DW'(ax) - DW'(ox);
    day_r <= DW'(ay) - DW'(oy);
    dbx_r <= DW'(bx) - DW'(ox);
    dby_r <= DW'(by) - DW'(oy);
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    l_r   <= PW'(dax_r) * PW'(dby_r);
    r_r   <= PW'(day_r) * PW'(dbx_r);
    sax_r <= PW'(dax_r) * PW'(dax_r);
    say_r <= PW'(day_r) * PW'(day_r);
    sbx_r <= PW'(dbx_r) * PW'(dbx_r);
    sby_r <= PW'(dby_r) * PW'(dby_r);
  end

  assign da2 = (PW+1)'(sax_r) + (PW+1)'(say_r);
  assign db2 = (PW+1)'(sbx_r) + (PW+1)'(sby_r);

  assign res.turn_pos  = l_r > r_r;
  assign res.turn_zero = l_r == r_r;
  assign res.dist_lt   = da2 < db2;

endmodule

[rtl/convex_hull_graham_core.sv]
`timescale 1ns / 1ps
// Top level of the Graham-scan convex hull core.
// Depends on chg_pkg and chg_turn.
//
// Points load at one beat per cycle into a point memory until a beat with
// in_tlast; beats beyond MAX_POINTS are dropped and every vertex of that set
// then carries out_tuser = 1. The core then runs from its point memory: a
// pivot search (a read and a check per point), a swap, an insertion sort by
// angle around the pivot (each element shift reads, loads and waits on the
// pipelined turn unit), and a Graham scan over a vertex stack memory (each
// turn test also waits on the turn unit). Vertices leave counterclockwise
// from the pivot, each beat read, loaded and held through output stalls, the
// final one with out_tlast. Input is not taken until the last vertex of the
// set has been delivered.
module convex_hull_graham_core #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // px[15:0], py[31:16]
  input  logic        in_tlast,   // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // hull_x[15:0], hull_y[31:16]
  output logic        out_tlast,  // last_vertex
  output logic        out_tuser   // overflow
);

  localparam int CW = COORD_WIDTH;
  localparam int PTW = 2 * CW;
  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);

  chg_pkg::state_t state_r, state_nxt;

  // point is {y, x}
  logic [PTW-1:0] pts_mem [MAX_POINTS];
  logic [PTW-1:0] stk_mem [MAX_POINTS];
  logic [PTW-1:0] pts_q, stk_q, pts_wdata, stk_wdata;
  logic [IW-1:0]  pts_raddr, pts_waddr, stk_raddr, stk_waddr;
  logic           pts_we, stk_we;

  logic [NW-1:0]  n_r, n_nxt, d_r, d_nxt;
  logic           drop_r, drop_nxt, small_r, small_nxt;
  logic [IW-1:0]  i_r, i_nxt, j_r, j_nxt, best_idx_r, best_idx_nxt;
  logic [PTW-1:0] best_r, best_nxt, pivot_r, pivot_nxt, key_r, key_nxt;
  logic [PTW-1:0] prev_r, prev_nxt, top_r, top_nxt, sec_r, sec_nxt;
  logic [PTW-1:0] co_r, co_nxt, ca_r, ca_nxt, cb_r, cb_nxt;
  logic [1:0]     cc_r, cc_nxt;
  logic [31:0]    od_r, od_nxt;
  logic           ol_r, ol_nxt, ou_r, ou_nxt, ov_r, ov_nxt;

  logic [PTW-1:0] in_pt, emit_pt;
  logic [31:0]    emit_data;
  chg_pkg::turn_res_t tres;
  logic           in_acc, i_end, p_less, do_push, cmp_done;
  int             ecnt;

  // coordinates: low CW bits of the 16-bit field, output sign-extended to 16
  always_comb begin
    for (int b = 0; b < CW; b++) begin
      in_pt[b]      = (b < 16) ? in_tdata[b] : 1'b0;
      in_pt[CW + b] = (b < 16) ? in_tdata[16 + b] : 1'b0;
    end
  end

  assign emit_pt = small_r ? pts_q : stk_q;
  always_comb begin
    for (int b = 0; b < 16; b++) begin
      emit_data[b]      = (b < CW) ? emit_pt[b] : emit_pt[CW-1];
      emit_data[16 + b] = (b < CW) ? emit_pt[CW + b] : emit_pt[PTW-1];
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (pts_we) begin
      pts_mem[pts_waddr] <= pts_wdata;
    end
    pts_q <= pts_mem[pts_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  chg_turn #(.CW(CW)) u_turn (
    .clk (clk),
    .ox  (co_r[CW-1:0]),
    .oy  (co_r[PTW-1:CW]),
    .ax  (ca_r[CW-1:0]),
    .ay  (ca_r[PTW-1:CW]),
    .bx  (cb_r[CW-1:0]),
    .by  (cb_r[PTW-1:CW]),
    .res (tres)
  );

  assign in_tready  = (state_r == chg_pkg::S_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign i_end      = (NW'(i_r) == n_r - NW'(1));
  assign cmp_done   = (cc_r == 2'(chg_pkg::CMP_LAT));
  assign ecnt       = (32'(d_r) > chg_pkg::MAX_RESULTS) ? chg_pkg::MAX_RESULTS : 32'(d_r);
  assign p_less     = ($signed(pts_q[PTW-1:CW]) < $signed(best_r[PTW-1:CW])) ||
                      ((pts_q[PTW-1:CW] == best_r[PTW-1:CW]) &&
                       ($signed(pts_q[CW-1:0]) < $signed(best_r[CW-1:0])));

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

  always_comb begin
    state_nxt    = state_r;
    n_nxt        = n_r;
    d_nxt        = d_r;
    drop_nxt     = drop_r;
    small_nxt    = small_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    pivot_nxt    = pivot_r;
    key_nxt      = key_r;
    prev_nxt     = prev_r;
    top_nxt      = top_r;
    sec_nxt      = sec_r;
    co_nxt       = co_r;
    ca_nxt       = ca_r;
    cb_nxt       = cb_r;
    cc_nxt       = (cc_r == 2'(chg_pkg::CMP_LAT)) ? cc_r : cc_r + 2'd1;
    od_nxt       = od_r;
    ol_nxt       = ol_r;
    ou_nxt       = ou_r;
    ov_nxt       = ov_r;
    pts_we       = 1'b0;
    pts_waddr    = j_r;
    pts_wdata    = key_r;
    pts_raddr    = i_r;
    stk_we       = 1'b0;
    stk_waddr    = d_r[IW-1:0];
    stk_wdata    = key_r;
    stk_raddr    = i_r;
    do_push      = 1'b0;

    unique case (state_r)
      chg_pkg::S_LOAD: begin
        if (in_acc) begin
          if (n_r < NW'(MAX_POINTS)) begin
            pts_we    = 1'b1;
            pts_waddr = n_r[IW-1:0];
            pts_wdata = in_pt;
            n_nxt     = n_r + NW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_tlast) begin
            i_nxt     = '0;
            state_nxt = chg_pkg::S_PV_RD;
          end
        end
      end
      chg_pkg::S_PV_RD: begin
        state_nxt = chg_pkg::S_PV_CHK;
      end
      chg_pkg::S_PV_CHK: begin
        if (i_r == '0 || p_less) begin
          best_nxt     = pts_q;
          best_idx_nxt = i_r;
        end
        if (i_end) begin
          i_nxt     = '0;
          state_nxt = chg_pkg::S_SWAP_RD;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = chg_pkg::S_PV_RD;
        end
      end
      chg_pkg::S_SWAP_RD: begin
        state_nxt = chg_pkg::S_SWAP_WR;
      end
      chg_pkg::S_SWAP_WR: begin
        pts_we    = 1'b1;
        pts_waddr = best_idx_r;
        pts_wdata = pts_q;
        state_nxt = chg_pkg::S_SWAP_W0;
      end
      chg_pkg::S_SWAP_W0: begin
        pts_we    = 1'b1;
        pts_waddr = '0;
        pts_wdata = best_r;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = best_r;
        pivot_nxt = best_r;
        if (32'(n_r) < chg_pkg::MIN_HULL) begin
          small_nxt = 1'b1;
          d_nxt     = n_r;
          i_nxt     = '0;
          state_nxt = chg_pkg::S_EMIT_RD;
        end else begin
          small_nxt = 1'b0;
          i_nxt     = IW'(2);
          state_nxt = chg_pkg::S_SORT_RD;
        end
      end
      chg_pkg::S_SORT_RD: begin
        state_nxt = chg_pkg::S_SORT_KEY;
      end
      chg_pkg::S_SORT_KEY: begin
        key_nxt   = pts_q;
        j_nxt     = i_r;
        state_nxt = chg_pkg::S_INS_RD;
      end
      chg_pkg::S_INS_RD: begin
        pts_raddr = j_r - IW'(1);
        if (j_r > IW'(1)) begin
          state_nxt = chg_pkg::S_INS_LD;
        end else begin
          pts_we = 1'b1;
          if (i_end) begin
            state_nxt = chg_pkg::S_SC_INIT_RD;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = chg_pkg::S_SORT_RD;
          end
        end
      end
      chg_pkg::S_INS_LD: begin
        prev_nxt  = pts_q;
        co_nxt    = pivot_r;
        ca_nxt    = key_r;
        cb_nxt    = pts_q;
        cc_nxt    = '0;
        state_nxt = chg_pkg::S_INS_CMP;
      end
      chg_pkg::S_INS_CMP: begin
        if (cmp_done) begin
          pts_we = 1'b1;
          if (tres.turn_pos || (tres.turn_zero && tres.dist_lt)) begin
            // key goes before prev: shift prev up one slot
            pts_wdata = prev_r;
            j_nxt     = j_r - IW'(1);
            state_nxt = chg_pkg::S_INS_RD;
          end else if (i_end) begin
            state_nxt = chg_pkg::S_SC_INIT_RD;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = chg_pkg::S_SORT_RD;
          end
        end
      end
      chg_pkg::S_SC_INIT_RD: begin
        pts_raddr = IW'(1);
        state_nxt = chg_pkg::S_SC_INIT;
      end
      chg_pkg::S_SC_INIT: begin
        stk_we    = 1'b1;
        stk_waddr = IW'(1);
        stk_wdata = pts_q;
        top_nxt   = pts_q;
        sec_nxt   = pivot_r;
        d_nxt     = NW'(2);
        i_nxt     = IW'(2);
        state_nxt = chg_pkg::S_SC_RD;
      end
      chg_pkg::S_SC_RD: begin
        state_nxt = chg_pkg::S_SC_LD;
      end
      chg_pkg::S_SC_LD: begin
        key_nxt   = pts_q;
        state_nxt = chg_pkg::S_SC_TEST;
      end
      chg_pkg::S_SC_TEST: begin
        if (d_r >= NW'(2)) begin
          co_nxt    = sec_r;
          ca_nxt    = top_r;
          cb_nxt    = key_r;
          cc_nxt    = '0;
          state_nxt = chg_pkg::S_SC_CMP;
        end else begin
          do_push = 1'b1;
        end
      end
      chg_pkg::S_SC_CMP: begin
        if (cmp_done) begin
          if (!tres.turn_pos) begin
            top_nxt = sec_r;
            d_nxt   = d_r - NW'(1);
            // refill the second entry from the stack memory
            stk_raddr = IW'(d_r - NW'(3));
            if (d_r >= NW'(3)) begin
              state_nxt = chg_pkg::S_SC_SEC;
            end else begin
              state_nxt = chg_pkg::S_SC_TEST;
            end
          end else begin
            do_push = 1'b1;
          end
        end
      end
      chg_pkg::S_SC_SEC: begin
        sec_nxt   = stk_q;
        state_nxt = chg_pkg::S_SC_TEST;
      end
      chg_pkg::S_EMIT_RD: begin
        state_nxt = chg_pkg::S_EMIT_LD;
      end
      chg_pkg::S_EMIT_LD: begin
        od_nxt    = emit_data;
        ol_nxt    = (32'(i_r) + 1 == ecnt);
        ou_nxt    = drop_r;
        ov_nxt    = 1'b1;
        state_nxt = chg_pkg::S_EMIT_OUT;
      end
      chg_pkg::S_EMIT_OUT: begin
        if (out_tready) begin
          ov_nxt = 1'b0;
          if (ol_r) begin
            n_nxt     = '0;
            d_nxt     = '0;
            drop_nxt  = 1'b0;
            state_nxt = chg_pkg::S_LOAD;
          end else begin
            i_nxt     = i_r + IW'(1);
            state_nxt = chg_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = chg_pkg::S_LOAD;
      end
    endcase

    if (do_push) begin
      stk_we    = 1'b1;
      stk_waddr = d_r[IW-1:0];
      stk_wdata = key_r;
      sec_nxt   = top_r;
      top_nxt   = key_r;
      d_nxt     = d_r + NW'(1);
      if (i_end) begin
        i_nxt     = '0;
        state_nxt = chg_pkg::S_EMIT_RD;
      end else begin
        i_nxt     = i_r + IW'(1);
        state_nxt = chg_pkg::S_SC_RD;
      end
    end

    if (state_nxt == chg_pkg::S_EMIT_RD) begin
      pts_raddr = i_nxt;
      stk_raddr = i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chg_pkg::S_LOAD;
      n_r     <= '0;
      d_r     <= '0;
      drop_r  <= 1'b0;
      ov_r    <= 1'b0;
      cc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      d_r     <= d_nxt;
      drop_r  <= drop_nxt;
      ov_r    <= ov_nxt;
      cc_r    <= cc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    small_r    <= small_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    pivot_r    <= pivot_nxt;
    key_r      <= key_nxt;
    prev_r     <= prev_nxt;
    top_r      <= top_nxt;
    sec_r      <= sec_nxt;
    co_r       <= co_nxt;
    ca_r       <= ca_nxt;
    cb_r       <= cb_nxt;
    od_r       <= od_nxt;
    ol_r       <= ol_nxt;
    ou_r       <= ou_nxt;
  end

`ifndef NO_ASSERTIONS
  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> state_r == chg_pkg::S_EMIT_OUT)
    else $error("result beat outside emit phase");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(MAX_POINTS))
    else $error("point count above capacity");

  a_stack_le_points: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != chg_pkg::S_LOAD) |-> d_r <= n_r)
    else $error("stack deeper than point set");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (n_r == '0 && !drop_r && in_tready))
    else $error("set not cleared after final vertex");
`endif

endmodule
